>>> sv/skt_pkg.sv
// ============================================================================
// skt_pkg: shared types and codes for the sorted key table
// Request and response transfer formats, request kinds, status codes and the
// control bundle that the table broadcasts to its row of key cells.
// ============================================================================
package skt_pkg;

    // Request kinds.
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_REWIND = 3'd4;
    localparam logic [2:0] REQ_NEXT   = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_END     = 2'd3;

    // One request transfer.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] key;
    } req_t;

    // One response transfer.
    typedef struct packed {
        logic [31:0] item_out;
        logic        found;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        full_res;
    } rsp_t;

    // Update controls broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

>>> sv/skt_cell.sv
// ============================================================================
// skt_cell: one entry of the sorted key table
// Holds one key, compares it against the broadcast request key, and on an
// insert takes the request key or the left neighbor's, on delete the right's.
// ============================================================================
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic                valid,
    input  logic                prev_lt,
    input  logic [KEY_BITS-1:0] prev_key,
    input  logic [KEY_BITS-1:0] next_key,
    output logic                lt,
    output logic                hit,
    output logic [KEY_BITS-1:0] key
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    // Compare the stored key; entries past the count never match.
    assign lt  = valid && (key_reg < req_key);
    assign hit = valid && !lt && prev_lt && (key_reg == req_key);
    assign key = key_reg;

    // Entries at or after the insert point shift up; at or after the
    // deleted entry they shift down.
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins_en && !lt)
        begin
            key_next = prev_lt ? req_key : prev_key;
        end
        else if (ctrl.del_en && !lt)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

>>> sv/sorted_key_table.sv
// ============================================================================
// sorted_key_table: ascending key table built from a row of key cells
// Insert, delete, lookup, clear, rewind and read-next requests, one response
// per request carrying the count and a full flag.
// ============================================================================
//
//  channel   signals                        direction   payload
//  request   req_valid, req_stall, req      in          req_t
//  response  rsp_valid, rsp_stall, rsp      out         rsp_t
//
//  Each request is first registered; then every cell compares against the
//  key in parallel and shifts with its neighbor.
//  req_stall is high while a request executes; a result waiting in the
//  response register does not block the next transfer, but execution
//  holds until that register is free. Reset clears count and cursor; the
//  key cells are not reset.
//
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic                busy_reg;
    logic [2:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W-1:0]    cur_reg;
    logic [CNT_W-1:0]    cur_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic                accept;
    logic                commit;
    logic                full;
    logic                found_any;
    logic                can_read;
    logic [KEY_BITS-1:0] read_key;
    cell_ctrl_t          ctrl;

    logic [TABLE_DEPTH-1:0] cell_lt;
    logic [TABLE_DEPTH-1:0] cell_hit;
    logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];

    // Handshake: one request in flight; it commits once the response
    // register is empty or being drained.
    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign commit    = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Row of key cells, each linked to its neighbors.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                c_prev_lt;
        logic [KEY_BITS-1:0] c_prev_key;
        logic [KEY_BITS-1:0] c_next_key;

        if (i == 0)
        begin : g_first
            assign c_prev_lt  = 1'b1;
            assign c_prev_key = '0;
        end
        else
        begin : g_mid
            assign c_prev_lt  = cell_lt[i-1];
            assign c_prev_key = cell_key[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign c_next_key = cell_key[i];
        end
        else
        begin : g_inner
            assign c_next_key = cell_key[i+1];
        end

        skt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .req_key  (key_reg),
            .valid    (CNT_W'(i) < cnt_reg),
            .prev_lt  (c_prev_lt),
            .prev_key (c_prev_key),
            .next_key (c_next_key),
            .lt       (cell_lt[i]),
            .hit      (cell_hit[i]),
            .key      (cell_key[i])
        );
    end

    // Table-wide flags and the key under the read cursor.
    assign full      = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign found_any = |cell_hit;
    assign can_read  = (cur_reg < cnt_reg);
    assign read_key  = cell_key[cur_reg[IDX_W-1:0]];

    assign ctrl.ins_en = commit && (op_reg == REQ_INSERT) && !full;
    assign ctrl.del_en = commit && (op_reg == REQ_DELETE) && found_any;

    // Count, cursor and response for the executing request.
    always_comb
    begin
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        rsp_next.item_out = '0;
        rsp_next.found    = 1'b0;
        rsp_next.status   = ST_OK;
        unique case (op_reg)
            REQ_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (found_any)
                begin
                    rsp_next.found = 1'b1;
                    cnt_next       = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            REQ_LOOKUP:
            begin
                if (found_any)
                begin
                    rsp_next.found    = 1'b1;
                    rsp_next.item_out = 32'(key_reg);
                end
                else
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            REQ_CLEAR:
            begin
                cnt_next = '0;
            end
            REQ_REWIND:
            begin
                cur_next = '0;
            end
            REQ_NEXT:
            begin
                if (can_read)
                begin
                    rsp_next.item_out = 32'(read_key);
                    cur_next          = cur_reg + CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_END;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        rsp_next.count    = 7'(cnt_next);
        rsp_next.full_res = (cnt_next == CNT_W'(TABLE_DEPTH));
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end

            if (commit)
            begin
                cnt_reg       <= cnt_next;
                cur_reg       <= cur_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and response payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.req_type;
            key_reg <= KEY_BITS'(req.key);
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
